FILE: rtl/rrd_pkg.sv
package rrd_pkg;

    // Ring geometry and frame limits
    localparam int unsigned RING_SIZE = 8192;
    localparam int unsigned FRAME_MAX = 1600;
    localparam int unsigned OFFS_W    = $clog2(RING_SIZE);

    localparam logic [11:0] CRC_BYTES    = 12'd4;
    localparam logic [15:0] RD_PTR_BIAS  = 16'h0010;
    localparam logic [11:0] CAP_RESET    = 12'd1514;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    // Header error codes
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_RX_OK  = 2'd1,
        ERR_LENGTH = 2'd2
    } err_t;

    // Outcome of the header check
    typedef struct packed {
        logic bad;
        err_t code;
        logic crc_only;
    } hdr_chk_t;

endpackage

FILE: rtl/rrd_hdr_check.sv
module rrd_hdr_check (
    input  logic              rx_ok,
    input  logic [11:0]       rec_len,
    input  logic [11:0]       capacity,
    output rrd_pkg::hdr_chk_t chk
);
    import rrd_pkg::*;

    logic [12:0] cap_limit;
    logic        len_bad;

    // length must cover the CRC and fit both the hard limit and the buffer
    assign cap_limit = {1'b0, capacity} + {1'b0, CRC_BYTES};
    assign len_bad   = (rec_len < CRC_BYTES)
                    || ({1'b0, rec_len} > 13'(FRAME_MAX))
                    || ({1'b0, rec_len} > cap_limit);

    // receive-OK bit takes priority over the length test
    always_comb
    begin
        chk.crc_only = (rec_len == CRC_BYTES);
        if (!rx_ok)
        begin
            chk.bad  = 1'b1;
            chk.code = ERR_RX_OK;
        end
        else if (len_bad)
        begin
            chk.bad  = 1'b1;
            chk.code = ERR_LENGTH;
        end
        else
        begin
            chk.bad  = 1'b0;
            chk.code = ERR_NONE;
        end
    end

endmodule

FILE: rtl/rx_ring_record_deframer.sv
// Channel   Handshake              Word
// ring in   in_valid / in_ready    ring_byte
// result    out_valid / out_ready  result_kind, payload_byte, payload_first,
//                                  payload_length, read_pointer, error_code
// config    cfg_wr_en              cfg_wr_data (frame capacity)
//
// One ring byte per cycle while in_ready is high; each byte is decoded by the
// phase logic in the same cycle it is taken; any result is then registered.
// in_ready is low only while a result sits unaccepted and out_ready is low.
// rst_n clears the phase, counters, ring offset and capacity (1514) at once.
// After a header error all bytes are taken and dropped until reset.
module rx_ring_record_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ring_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic        payload_first,
    output logic [10:0] payload_length,
    output logic [15:0] read_pointer,
    output logic [1:0]  error_code
);
    import rrd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC,
        PH_PAD,
        PH_HALT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [11:0]        cap_reg, cap_next;
    logic               rx_ok_reg, rx_ok_next;
    logic [7:0]         len_lo_reg, len_lo_next;
    logic [11:0]        count_reg, count_next;
    logic [11:0]        rec_len_reg, rec_len_next;
    logic [OFFS_W-1:0]  offset_reg, offset_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [7:0]         byte_reg, byte_next;
    logic               first_reg, first_next;
    logic [10:0]        len_out_reg, len_out_next;
    logic [15:0]        rd_ptr_reg, rd_ptr_next;
    err_t               err_reg, err_next;

    logic               in_acc;
    logic               res_valid;
    logic [11:0]        hdr_len;
    hdr_chk_t           chk;
    logic [11:0]        count_inc;
    logic [11:0]        pay_len;
    logic [1:0]         pad_len;
    logic [OFFS_W:0]    rec_end;
    logic [OFFS_W-1:0]  next_offset;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // header length from byte 2 and the low nibble of byte 3
    assign hdr_len = {ring_byte[3:0], len_lo_reg};

    rrd_hdr_check u_hdr_check (
        .rx_ok    (rx_ok_reg),
        .rec_len  (hdr_len),
        .capacity (cap_reg),
        .chk      (chk)
    );

    // record geometry: offset stays word aligned, so pad is just -len mod 4
    assign count_inc = count_reg + 12'd1;
    assign pay_len   = rec_len_reg - CRC_BYTES;
    assign pad_len   = 2'(~rec_len_reg[1:0] + 2'd1);
    assign rec_end   = ({1'b0, offset_reg} + (OFFS_W+1)'(rec_len_reg) + (OFFS_W+1)'(7))
                     & ~(OFFS_W+1)'(3);
    // end stays below twice the ring size, one subtract wraps it
    assign next_offset = (rec_end >= (OFFS_W+1)'(RING_SIZE))
                       ? OFFS_W'(rec_end - (OFFS_W+1)'(RING_SIZE))
                       : OFFS_W'(rec_end);

    // phase logic and result build
    always_comb
    begin
        phase_next   = phase_reg;
        cap_next     = cfg_wr_en ? cfg_wr_data : cap_reg;
        rx_ok_next   = rx_ok_reg;
        len_lo_next  = len_lo_reg;
        count_next   = count_reg;
        rec_len_next = rec_len_reg;
        offset_next  = offset_reg;

        res_valid    = 1'b0;
        kind_next    = KIND_PAYLOAD;
        byte_next    = 8'd0;
        first_next   = 1'b0;
        len_out_next = 11'd0;
        rd_ptr_next  = 16'd0;
        err_next     = ERR_NONE;

        if (in_acc)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    count_next = count_inc;
                    unique case (count_reg[1:0])
                        2'd0:    rx_ok_next  = ring_byte[0];
                        2'd2:    len_lo_next = ring_byte;
                        2'd3:
                        begin
                            count_next   = 12'd0;
                            rec_len_next = hdr_len;
                            if (chk.bad)
                            begin
                                phase_next = PH_HALT;
                                res_valid  = 1'b1;
                                kind_next  = KIND_ERROR;
                                err_next   = chk.code;
                            end
                            else
                            begin
                                phase_next = chk.crc_only ? PH_CRC : PH_PAYLOAD;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_PAYLOAD:
                begin
                    res_valid  = 1'b1;
                    kind_next  = KIND_PAYLOAD;
                    byte_next  = ring_byte;
                    first_next = (count_reg == 12'd0);
                    if (count_inc >= pay_len)
                    begin
                        phase_next = PH_CRC;
                        count_next = 12'd0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_CRC:
                begin
                    if (count_inc == CRC_BYTES)
                    begin
                        count_next = 12'd0;
                        phase_next = (pad_len == 2'd0) ? PH_HEADER : PH_PAD;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_PAD:
                begin
                    count_next = (count_inc == {10'd0, pad_len}) ? 12'd0 : count_inc;
                    if (count_inc == {10'd0, pad_len})
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HALT: ;
                default: ;
            endcase

            // record complete: on last CRC byte when aligned, else last pad byte
            if ((phase_reg == PH_CRC && count_inc == CRC_BYTES && pad_len == 2'd0)
                || (phase_reg == PH_PAD && count_inc == {10'd0, pad_len}))
            begin
                res_valid    = 1'b1;
                kind_next    = KIND_COMPLETE;
                len_out_next = pay_len[10:0];
                rd_ptr_next  = 16'(next_offset) - RD_PTR_BIAS;
                offset_next  = next_offset;
                rx_ok_next   = 1'b0;
                len_lo_next  = 8'd0;
            end
        end

        // output register: refill on a new result, drop when taken
        if (in_acc)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            cap_reg       <= CAP_RESET;
            rx_ok_reg     <= 1'b0;
            len_lo_reg    <= 8'd0;
            count_reg     <= 12'd0;
            rec_len_reg   <= 12'd0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_PAYLOAD;
            byte_reg      <= 8'd0;
            first_reg     <= 1'b0;
            len_out_reg   <= 11'd0;
            rd_ptr_reg    <= 16'd0;
            err_reg       <= ERR_NONE;
        end
        else
        begin
            phase_reg     <= phase_next;
            cap_reg       <= cap_next;
            rx_ok_reg     <= rx_ok_next;
            len_lo_reg    <= len_lo_next;
            count_reg     <= count_next;
            rec_len_reg   <= rec_len_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
            if (in_acc && res_valid)
            begin
                kind_reg    <= kind_next;
                byte_reg    <= byte_next;
                first_reg   <= first_next;
                len_out_reg <= len_out_next;
                rd_ptr_reg  <= rd_ptr_next;
                err_reg     <= err_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign payload_byte   = byte_reg;
    assign payload_first  = first_reg;
    assign payload_length = len_out_reg;
    assign read_pointer   = rd_ptr_reg;
    assign error_code     = err_reg;

endmodule

FILE: rtl/rrd_checker.sv
module rrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [7:0]  payload_byte,
    input logic        payload_first,
    input logic [10:0] payload_length,
    input logic [15:0] read_pointer,
    input logic [1:0]  error_code
);
    import rrd_pkg::*;

    // an empty output register never holds back the ring
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with output register empty");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(payload_first)
            && $stable(payload_length) && $stable(read_pointer)
            && $stable(error_code))
        else $error("result word changed while stalled");

    // error code set exactly on error words
    a_err_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // first-byte flag only on payload words
    a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_first |-> result_kind == KIND_PAYLOAD)
        else $error("first flag on non-payload word");

    // nothing follows a header error
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && result_kind == KIND_ERROR |=> !out_valid)
        else $error("result after header error");

endmodule

bind rx_ring_record_deframer rrd_checker u_rrd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .payload_first  (payload_first),
    .payload_length (payload_length),
    .read_pointer   (read_pointer),
    .error_code     (error_code)
);
